/* rtl/core/jse_pkg.sv */
package jse_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       first_byte;
		logic       last_byte;
	} src_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       string_end;
	} dst_t;

	typedef enum logic [1:0] {
		KIND_RAW,
		KIND_SHORT,
		KIND_UNI
	} kind_t;

	// classified request as it sits in the queue; the closing quote is
	// implied by last_idx running past the escape bytes
	typedef struct packed {
		logic       open_q;
		kind_t      kind;
		logic [7:0] ch;       // raw byte, or second char of a short escape
		logic [2:0] esc_len;  // 0, 1, 2 or 6
		logic [2:0] last_idx; // index of the final output byte
	} desc_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return CH_ZERO + {4'd0, nib};
		end
		return CH_LOWER_A + {4'd0, nib} - 8'd10;
	endfunction

endpackage

/* rtl/core/jse_front.sv */
module jse_front (
	input  logic           src_valid,
	output logic           src_ready,
	input  jse_pkg::src_t  src_data,
	output logic           push,
	output jse_pkg::desc_t push_desc,
	input  logic           full
);

	logic [7:0] short_ch;
	logic [3:0] cnt;

	always_comb begin
		push_desc        = '0;
		short_ch         = 8'h00;
		push_desc.open_q  = src_data.first_byte;
		push_desc.ch      = src_data.data_byte;
		push_desc.kind    = jse_pkg::KIND_RAW;
		push_desc.esc_len = 3'd0;
		case (src_data.data_byte)
			jse_pkg::CH_QUOTE:  short_ch = jse_pkg::CH_QUOTE;
			jse_pkg::CH_SLASH:  short_ch = jse_pkg::CH_SLASH;
			jse_pkg::CH_BSLASH: short_ch = jse_pkg::CH_BSLASH;
			8'd8:               short_ch = 8'h62; // b
			8'd9:               short_ch = 8'h74; // t
			8'd10:              short_ch = 8'h6E; // n
			8'd12:              short_ch = 8'h66; // f
			8'd13:              short_ch = 8'h72; // r
			default:            short_ch = 8'h00;
		endcase
		if (src_data.has_byte) begin
			if (short_ch != 8'h00) begin
				push_desc.kind    = jse_pkg::KIND_SHORT;
				push_desc.ch      = short_ch;
				push_desc.esc_len = 3'd2;
			end else if (src_data.data_byte inside {[8'd1:8'd31], jse_pkg::CH_DEL}) begin
				push_desc.kind    = jse_pkg::KIND_UNI;
				push_desc.esc_len = 3'd6;
			end else begin
				push_desc.esc_len = 3'd1;
			end
		end
		cnt = {3'd0, src_data.first_byte} + {1'b0, push_desc.esc_len}
			+ {3'd0, src_data.last_byte};
		push_desc.last_idx = 3'(cnt - 4'd1);
	end

	assign src_ready = !full;
	// requests that produce no output are taken and dropped
	assign push = src_valid && !full && (push_desc.esc_len != 3'd0
		|| src_data.first_byte || src_data.last_byte);

endmodule

/* rtl/core/jse_queue.sv */
module jse_queue #(
	parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jse_pkg::desc_t push_desc,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output jse_pkg::desc_t head_desc
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jse_pkg::desc_t mem [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_desc  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/jse_back.sv */
module jse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  jse_pkg::desc_t head_desc,
	output logic           pop,
	output logic           dst_valid,
	input  logic           dst_ready,
	output jse_pkg::dst_t  dst_data
);

	logic [2:0]    pos_q;
	logic [2:0]    j;
	logic          load;
	logic          at_end;
	jse_pkg::dst_t next_res;
	logic [7:0]    esc_ch;
	logic          dst_valid_q;
	jse_pkg::dst_t dst_q;

	assign load   = head_valid && (!dst_valid_q || dst_ready);
	assign at_end = pos_q == head_desc.last_idx;
	assign pop    = load && at_end;
	assign j      = pos_q - {2'd0, head_desc.open_q};

	always_comb begin
		case (head_desc.kind)
			jse_pkg::KIND_SHORT: esc_ch = (j == 3'd0) ? jse_pkg::CH_BSLASH : head_desc.ch;
			jse_pkg::KIND_UNI: begin
				case (j)
					3'd0:    esc_ch = jse_pkg::CH_BSLASH;
					3'd1:    esc_ch = jse_pkg::CH_U;
					3'd4:    esc_ch = jse_pkg::hex_char(head_desc.ch[7:4]);
					3'd5:    esc_ch = jse_pkg::hex_char(head_desc.ch[3:0]);
					default: esc_ch = jse_pkg::CH_ZERO;
				endcase
			end
			default: esc_ch = head_desc.ch;
		endcase
	end

	always_comb begin
		next_res.run_end    = at_end;
		next_res.string_end = 1'b0;
		if (head_desc.open_q && pos_q == 3'd0) begin
			next_res.out_byte = jse_pkg::CH_QUOTE;
		end else if (j < head_desc.esc_len) begin
			next_res.out_byte = esc_ch;
		end else begin
			next_res.out_byte   = jse_pkg::CH_QUOTE;
			next_res.string_end = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			dst_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q       <= at_end ? 3'd0 : pos_q + 3'd1;
				dst_valid_q <= 1'b1;
			end else if (dst_ready) begin
				dst_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dst_q <= next_res;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_q;

endmodule

/* rtl/core/json_string_escaper.sv */
// A taken request is first written to the queue, then loaded into the output register.
// Throughput: one request per cycle while the queue has room; the output side
// emits one byte per cycle unless dst_ready stalls it; a request makes 1 to 8 bytes.
// The queue (QUEUE_DEPTH entries) lets the input run ahead of multi-byte escapes.
// Reset (arst_n low) empties the queue and the output register at once.
module json_string_escaper #(
	parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_ready,
	input  jse_pkg::src_t src_data,
	output logic          dst_valid,
	input  logic          dst_ready,
	output jse_pkg::dst_t dst_data
);

	logic           push;
	logic           full;
	logic           pop;
	logic           head_valid;
	jse_pkg::desc_t push_desc;
	jse_pkg::desc_t head_desc;

	jse_front u_front (
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.push      (push),
		.push_desc (push_desc),
		.full      (full)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	jse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.dst_valid  (dst_valid),
		.dst_ready  (dst_ready),
		.dst_data   (dst_data)
	);

endmodule
